>>> rtl/pde_pkg.sv
package pde_pkg;

  localparam int COEF_REGS      = 6;
  localparam int DEF_NUM_COEFFS = 6;
  localparam int COEF_W         = 48;
  localparam int X_W            = 32;
  localparam int RES_W          = 64;
  localparam int ORD_W          = 2;
  localparam int NUM_ORDERS     = 4;
  localparam int CFG_IDX_W      = $clog2(COEF_REGS);
  localparam int FACT_W         = 8;
  localparam int SUB_STAGES     = 5;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [X_W-1:0]    x_t;
  typedef logic signed [RES_W-1:0]  res_t;
  typedef logic        [ORD_W-1:0]  ord_t;

  localparam res_t RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam res_t RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // i * (i-1) * ... * (i-d+1)
  function automatic logic [FACT_W-1:0] falling_fact(input int i, input int d);
    int f;
    f = 1;
    for (int m = 0; m < d; m++) begin
      f = f * (i - m);
    end
    return FACT_W'(f);
  endfunction

  // coefficient times derivative factor, moved from Q.28 to Q.32
  function automatic res_t deriv_coef(input coef_t c, input logic [FACT_W-1:0] f);
    logic signed [COEF_W+FACT_W:0] p;
    p = c * $signed({1'b0, f});
    return RES_W'(p) <<< 4;
  endfunction

endpackage

>>> rtl/polynomial_derivative_evaluator.sv
// Polynomial / derivative evaluator, coefficients c_0 .. c_(NUM_COEFFS-1).
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index i
// writes coefficient c_i (signed Q20.28), higher indexes are dropped. Write
// only while no beat is in flight. cfg_ready is always high.
// Input channel: in_valid/in_stall with x_value (signed Q8.24) and
// derivative_order (0 value, 1..3 derivative order). One result beat per input
// beat on out_valid/out_stall: poly_result (signed Q32.32, saturated) and
// overflow_flag (some Horner step saturated).
// Each Horner step is five register stages (abs, 32x32 partial products,
// round/combine, sign/saturate, saturating add); there are NUM_COEFFS-1 steps
// plus an entry stage. Throughput is one beat per cycle when out_stall is low.
// Stall: each stage holds only while it is full and the stage after it holds,
// so bubbles close up and the input keeps flowing until the pipe is full.
// Reset clears all stage valid bits and zeroes the coefficients.
module polynomial_derivative_evaluator #(
  parameter int NUM_COEFFS = pde_pkg::DEF_NUM_COEFFS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  pde_pkg::coef_t                cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pde_pkg::x_t                   x_value,
  input  pde_pkg::ord_t                 derivative_order,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pde_pkg::res_t                 poly_result,
  output logic                          overflow_flag
);

  localparam int STEPS = NUM_COEFFS - 1;
  localparam int NST   = pde_pkg::SUB_STAGES * STEPS + 1;
  localparam int RW    = pde_pkg::RES_W;
  localparam int XW    = pde_pkg::X_W;
  localparam int HW    = RW / 2;

  pde_pkg::coef_t coef [pde_pkg::COEF_REGS];
  pde_pkg::res_t  b_term [NUM_COEFFS][pde_pkg::NUM_ORDERS];

  logic [NST-1:0] vld;
  logic [NST-1:0] vld_src;
  logic [NST:0]   en;

  // step boundary registers: 0 is the entry stage, s+1 the end of step s
  pde_pkg::res_t bnd_acc [STEPS+1];
  pde_pkg::x_t   bnd_x   [STEPS+1];
  pde_pkg::ord_t bnd_d   [STEPS+1];
  logic          bnd_ovf [STEPS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pde_pkg::COEF_REGS; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready &&
                 32'(cfg_index) < pde_pkg::COEF_REGS) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  // derivative coefficient table, zero beyond the polynomial
  for (genvar jj = 0; jj < NUM_COEFFS; jj++) begin : g_term
    for (genvar dd = 0; dd < pde_pkg::NUM_ORDERS; dd++) begin : g_ord
      localparam int I = jj + dd;
      if (I < NUM_COEFFS && I < pde_pkg::COEF_REGS) begin : g_on
        assign b_term[jj][dd] =
          pde_pkg::deriv_coef(coef[I], pde_pkg::falling_fact(I, dd));
      end else begin : g_off
        assign b_term[jj][dd] = '0;
      end
    end
  end

  // flow control
  assign en[NST]   = !out_stall;
  assign vld_src   = {vld[NST-2:0], in_valid};
  assign in_stall  = !en[0];
  assign out_valid = vld[NST-1];

  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld_src[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      bnd_acc[0] <= b_term[NUM_COEFFS-1][derivative_order];
      bnd_x[0]   <= x_value;
      bnd_d[0]   <= derivative_order;
      bnd_ovf[0] <= 1'b0;
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int J  = NUM_COEFFS - 2 - s;
    localparam int KB = pde_pkg::SUB_STAGES * s;

    // stage A: magnitudes
    logic [RW-1:0] a_ua;
    logic [XW-1:0] a_ux;
    logic          a_neg;
    pde_pkg::res_t a_b;
    pde_pkg::x_t   a_x;
    pde_pkg::ord_t a_d;
    logic          a_ovf;
    // stage B: partial products
    logic [RW-1:0] b_lo, b_hi;
    logic          b_neg;
    pde_pkg::res_t b_b;
    pde_pkg::x_t   b_x;
    pde_pkg::ord_t b_d;
    logic          b_ovf;
    // stage C: rounded magnitude
    logic [RW-1:0] c_r;
    logic          c_big, c_neg;
    pde_pkg::res_t c_b;
    pde_pkg::x_t   c_x;
    pde_pkg::ord_t c_d;
    logic          c_ovf;
    // stage D: signed, saturated product
    pde_pkg::res_t d_m;
    pde_pkg::res_t d_b;
    pde_pkg::x_t   d_x;
    pde_pkg::ord_t d_d;
    logic          d_ovf;

    pde_pkg::res_t   m_next;
    logic            m_ovf_next;
    logic [RW:0]     sum;

    always_ff @(posedge clk) begin
      if (en[KB+1]) begin
        a_ua  <= bnd_acc[s][RW-1] ? (~bnd_acc[s] + 1'b1) : bnd_acc[s];
        a_ux  <= bnd_x[s][XW-1] ? (~bnd_x[s] + 1'b1) : bnd_x[s];
        a_neg <= bnd_acc[s][RW-1] ^ bnd_x[s][XW-1];
        a_b   <= b_term[J][bnd_d[s]];
        a_x   <= bnd_x[s];
        a_d   <= bnd_d[s];
        a_ovf <= bnd_ovf[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en[KB+2]) begin
        b_lo  <= a_ua[HW-1:0] * a_ux;
        b_hi  <= a_ua[RW-1:HW] * a_ux;
        b_neg <= a_neg;
        b_b   <= a_b;
        b_x   <= a_x;
        b_d   <= a_d;
        b_ovf <= a_ovf;
      end
    end

    always_ff @(posedge clk) begin
      if (en[KB+3]) begin
        c_r   <= {b_hi[RW-9:0], 8'b0} + RW'(b_lo[RW-1:24]) + RW'(b_lo[23]);
        c_big <= |b_hi[RW-1:RW-9];
        c_neg <= b_neg;
        c_b   <= b_b;
        c_x   <= b_x;
        c_d   <= b_d;
        c_ovf <= b_ovf;
      end
    end

    always_comb begin
      m_next     = pde_pkg::res_t'(c_r);
      m_ovf_next = 1'b0;
      if (c_big) begin
        m_next     = c_neg ? pde_pkg::RES_MIN : pde_pkg::RES_MAX;
        m_ovf_next = 1'b1;
      end else if (!c_neg) begin
        if (c_r[RW-1]) begin
          m_next     = pde_pkg::RES_MAX;
          m_ovf_next = 1'b1;
        end
      end else if (c_r[RW-1]) begin
        m_next     = pde_pkg::RES_MIN;
        m_ovf_next = |c_r[RW-2:0];
      end else begin
        m_next = pde_pkg::res_t'(~c_r + 1'b1);
      end
    end

    always_ff @(posedge clk) begin
      if (en[KB+4]) begin
        d_m   <= m_next;
        d_b   <= c_b;
        d_x   <= c_x;
        d_d   <= c_d;
        d_ovf <= c_ovf | m_ovf_next;
      end
    end

    assign sum = {d_m[RW-1], d_m} + {d_b[RW-1], d_b};

    always_ff @(posedge clk) begin
      if (en[KB+5]) begin
        if (sum[RW] != sum[RW-1]) begin
          bnd_acc[s+1] <= sum[RW] ? pde_pkg::RES_MIN : pde_pkg::RES_MAX;
          bnd_ovf[s+1] <= 1'b1;
        end else begin
          bnd_acc[s+1] <= sum[RW-1:0];
          bnd_ovf[s+1] <= d_ovf;
        end
        bnd_x[s+1] <= d_x;
        bnd_d[s+1] <= d_d;
      end
    end
  end

  assign poly_result   = bnd_acc[STEPS];
  assign overflow_flag = bnd_ovf[STEPS];

endmodule

>>> dv/polynomial_derivative_evaluator_tb.sv
module polynomial_derivative_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef pde_pkg::coef_t coef_t;
  typedef pde_pkg::x_t    x_t;
  typedef pde_pkg::res_t  res_t;
  typedef pde_pkg::ord_t  ord_t;

  localparam int N_TERMS    = pde_pkg::DEF_NUM_COEFFS;
  localparam int COEF_REGS  = pde_pkg::COEF_REGS;
  localparam int COEF_W     = pde_pkg::COEF_W;
  localparam int RES_W      = pde_pkg::RES_W;
  localparam int CFG_IDX_W  = pde_pkg::CFG_IDX_W;
  localparam int NUM_ORDERS = pde_pkg::NUM_ORDERS;

  localparam res_t RES_MAX = pde_pkg::RES_MAX;
  localparam res_t RES_MIN = pde_pkg::RES_MIN;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam ord_t ORD_VALUE = 2'd0;
  localparam ord_t ORD_D1    = 2'd1;
  localparam ord_t ORD_D2    = 2'd2;
  localparam ord_t ORD_D3    = 2'd3;

  localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam coef_t ONE_Q28  = 48'sh0000_1000_0000;

  localparam x_t X_MAX  = 32'sh7fff_ffff;
  localparam x_t X_MIN  = 32'sh8000_0000;
  localparam x_t ONE_X  = 32'sh0100_0000;
  localparam x_t HALF_X = 32'sh0080_0000;

  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 78;

  typedef struct {
    x_t   x;
    ord_t ord;
  } eval_req_t;

  typedef struct {
    res_t value;
    logic ovf;
    x_t   x;
    ord_t ord;
  } eval_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  coef_t                cfg_data  = '0;

  logic in_valid = 1'b0;
  logic in_stall;
  x_t   x_value = '0;
  ord_t derivative_order = ORD_VALUE;

  logic out_valid;
  logic out_stall = 1'b0;
  res_t poly_result;
  logic overflow_flag;

  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  logic quiet     = 1'b0;

  coef_t     coef_shadow [COEF_REGS];
  eval_req_t req_q [$];
  eval_res_t awaited_q [$];
  eval_res_t want;

  int gap_left;
  int stall_left;
  int stall_pick;
  int mismatches;
  int n_checked;
  int n_sat;
  int n_sets;
  int n_backpressure;

  polynomial_derivative_evaluator #(.NUM_COEFFS(N_TERMS)) uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .x_value          (x_value),
    .derivative_order (derivative_order),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .poly_result      (poly_result),
    .overflow_flag    (overflow_flag)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout: %0d results still pending", awaited_q.size());
    $display("polynomial_derivative_evaluator_tb failed");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic res_t scaled_coef(input int j, input int d);
    int     k;
    longint f;
    k = j + d;
    f = 1;
    if (k >= COEF_REGS) return '0;
    for (int m = 0; m < d; m++) f = f * (k - m);
    return res_t'(longint'(coef_shadow[k]) * f * 16);
  endfunction

  // round-half-away(acc * x / 2^24), saturated
  function automatic res_t scale_by_x(input res_t acc, input x_t x, inout logic ovf);
    logic        neg;
    logic [63:0] ua, ux, p_lo, p_hi, r;
    neg  = (acc < 0) != (x < 0);
    ua   = acc[RES_W-1] ? (~acc + 64'd1) : acc;
    ux   = (x < 0) ? 64'(-longint'(x)) : 64'(longint'(x));
    p_lo = {32'd0, ua[31:0]} * ux;
    p_hi = {32'd0, ua[63:32]} * ux;
    if (p_hi >= 64'h0080_0000_0000_0000) begin
      ovf = 1'b1;
      return neg ? RES_MIN : RES_MAX;
    end
    r = (p_hi << 8) + ((p_lo + 64'h80_0000) >> 24);
    if (!neg) begin
      if (r[63]) begin
        ovf = 1'b1;
        return RES_MAX;
      end
      return res_t'(r);
    end
    if (r > 64'h8000_0000_0000_0000) begin
      ovf = 1'b1;
      return RES_MIN;
    end
    return res_t'(~r + 64'd1);
  endfunction

  function automatic res_t sat_sum(input res_t a, input res_t b, inout logic ovf);
    logic signed [RES_W:0] s;
    s = a + b;
    if (s[RES_W] != s[RES_W-1]) begin
      ovf = 1'b1;
      return s[RES_W] ? RES_MIN : RES_MAX;
    end
    return res_t'(s);
  endfunction

  function automatic res_t horner_eval(input x_t x, input ord_t ord, output logic ovf);
    int   top;
    res_t acc;
    ovf = 1'b0;
    acc = '0;
    top = N_TERMS - 1 - int'(ord);
    if (top >= 0) begin
      acc = scaled_coef(top, int'(ord));
      for (int j = top - 1; j >= 0; j--) begin
        acc = scale_by_x(acc, x, ovf);
        acc = sat_sum(acc, scaled_coef(j, int'(ord)), ovf);
      end
    end
    return acc;
  endfunction

  // ---------------- random values ----------------

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic coef_t pick_coef();
    case ($urandom_range(0, 5))
      0: return coef_t'({$urandom, $urandom});
      1: return coef_t'(int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
      2: return COEF_MAX;
      3: return COEF_MIN;
      4: return '0;
      default: return coef_t'(int'($urandom));
    endcase
  endfunction

  function automatic x_t pick_x();
    case ($urandom_range(0, 7))
      0, 1: return x_t'($urandom);
      2, 3, 4: return x_t'(int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      5: return x_t'(int'($urandom_range(0, 255)) - 128);
      6: begin
        case ($urandom_range(0, 4))
          0: return X_MAX;
          1: return X_MIN;
          2: return ONE_X;
          3: return -ONE_X;
          default: return '0;
        endcase
      end
      default: return x_t'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endcase
  endfunction

  function automatic void queue_req(input x_t x, input ord_t ord);
    eval_req_t r;
    r.x   = x;
    r.ord = ord;
    req_q = {req_q, r};
  endfunction

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0 && !quiet) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_q.size() != 0) begin
        in_valid         <= 1'b1;
        x_value          <= req_q[0].x;
        derivative_order <= req_q[0].ord;
        req_q.pop_front();
        gap_left         <= quiet ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver stall ----------------

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done  <= 1'b1;
      out_stall  <= 1'b1;
      stall_left <= HOLD_CYCLES;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      stall_pick = idle_len();
      out_stall  <= (stall_pick != 0);
      stall_left <= (stall_pick > 0) ? stall_pick - 1 : 0;
    end
  end

  // ---------------- monitor ----------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("result %h flag %b with none pending",
                                    poly_result, overflow_flag));
        end else begin
          want = awaited_q.pop_front();
          if (poly_result !== want.value)
            report_mismatch($sformatf("poly_result %h, want %h (x %h order %0d)",
                                      poly_result, want.value, want.x, want.ord));
          if (overflow_flag !== want.ovf)
            report_mismatch($sformatf("overflow_flag %b, want %b (x %h order %0d)",
                                      overflow_flag, want.ovf, want.x, want.ord));
          n_checked++;
          if (want.ovf) n_sat++;
        end
      end
      if (in_valid && !in_stall) begin
        want.value = horner_eval(x_value, derivative_order, want.ovf);
        want.x     = x_value;
        want.ord   = derivative_order;
        awaited_q  = {awaited_q, want};
      end
      if (in_valid && in_stall) n_backpressure++;
    end
  end

  // ---------------- stimulus ----------------

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input coef_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < COEF_REGS) coef_shadow[idx] = val;
  endtask

  task automatic wait_idle();
    do begin
      while (req_q.size() != 0 || in_valid || awaited_q.size() != 0) @(posedge clk);
      repeat (5 * N_TERMS) @(posedge clk);
    end while (req_q.size() != 0 || in_valid || awaited_q.size() != 0);
  endtask

  initial begin
    coef_t demo [COEF_REGS];
    x_t    demo_x [5];
    int    kind;

    foreach (coef_shadow[i]) coef_shadow[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // coefficients still at reset
    for (int o = 0; o < NUM_ORDERS; o++) queue_req(X_MAX, ord_t'(o));
    wait_idle();

    demo[0] = ONE_Q28 >>> 1;
    demo[1] = -(ONE_Q28 + (ONE_Q28 >>> 2));
    demo[2] = ONE_Q28 <<< 1;
    demo[3] = -(ONE_Q28 >>> 2) - 48'sd3;
    demo[4] = (ONE_Q28 >>> 3) + 48'sd1;
    demo[5] = ONE_Q28;
    for (int i = 0; i < COEF_REGS; i++) write_coef(cfg_idx_t'(i), demo[i]);
    // out-of-range indexes must be dropped
    write_coef(cfg_idx_t'(COEF_REGS), COEF_MAX);
    write_coef(cfg_idx_t'(COEF_REGS + 1), COEF_MIN);
    n_sets++;

    demo_x = '{X_MAX, X_MIN, '0, ONE_X, -HALF_X};
    foreach (demo_x[i]) begin
      queue_req(demo_x[i], ORD_VALUE);
      queue_req(demo_x[i], ORD_D1);
      queue_req(demo_x[i], ORD_D2);
      queue_req(demo_x[i], ORD_D3);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      kind = (p == 0) ? 1 : (p == 1) ? 2 : 0;
      for (int i = 0; i < COEF_REGS; i++)
        write_coef(cfg_idx_t'(i),
                   (kind == 1) ? COEF_MAX : (kind == 2) ? COEF_MIN : pick_coef());
      if ($urandom_range(0, 1))
        write_coef(cfg_idx_t'(COEF_REGS + $urandom_range(0, 1)), pick_coef());
      n_sets++;
      quiet <= (p == 6);
      if (p == 4) hold_req <= 1'b1;
      repeat (PHASE_ITEMS) queue_req(pick_x(), ord_t'($urandom_range(0, 3)));
    end

    wait_idle();
    quiet <= 1'b0;

    $display("checked %0d evaluations over %0d coefficient sets, %0d of them saturated",
             n_checked, n_sets, n_sat);
    $display("input beats held back for %0d cycles by a full pipe", n_backpressure);
    if (mismatches == 0) begin
      $display("polynomial_derivative_evaluator_tb passed");
    end else begin
      $display("polynomial_derivative_evaluator_tb failed");
    end
    $finish;
  end

endmodule
